@@ design/iteration_palette_color_top_macros.svh @@
// Assertion macros for the iteration palette color block.
// Used by iteration_palette_color_top; expects clk and rst_n in scope.
`ifndef ITERATION_PALETTE_COLOR_TOP_MACROS_SVH
`define ITERATION_PALETTE_COLOR_TOP_MACROS_SVH

// Same-cycle implication, held off during reset
`define IPC_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("palette color check failed");

// Next-cycle implication, held off during reset
`define IPC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("palette color check failed");

`endif

@@ design/ipc_pkg.sv @@
// Shared types and constants of the iteration palette color block.
// No dependencies; imported by every module of the block.
package ipc_pkg;

    localparam int IDX_W                   = 12;
    localparam int LIM_W                   = 13;
    localparam int REM_W                   = 12;
    localparam int MAX_ITERATIONS          = 4096;
    localparam int DEF_FRACTION_BITS       = 16;
    localparam int DEF_COSINE_TABLE_DEPTH  = 1024;

    localparam logic [23:0] KALEIDO_BASE = 24'h7f00ff;
    localparam logic [23:0] KALEIDO_STEP = 24'h0042f0;

    typedef enum logic [2:0] {
        MODE_BERNSTEIN = 3'd0,
        MODE_COSINE    = 3'd1,
        MODE_KALEIDO   = 3'd2,
        MODE_GREY      = 3'd3,
        MODE_MONO      = 3'd4
    } ipc_mode_e;

    // Register select bit (byte address bit 2)
    localparam logic REG_MODE  = 1'b0;
    localparam logic REG_LIMIT = 1'b1;

    localparam ipc_mode_e        MODE_RESET  = MODE_BERNSTEIN;
    localparam logic [LIM_W-1:0] LIMIT_RESET = 13'd64;

    // Per-request flags that ride along the pipeline
    typedef struct packed {
        logic        oob;
        logic        last;
        logic [23:0] kcolor;
    } ipc_side_t;

endpackage

@@ design/ipc_divider.sv @@
// Pipelined restoring divider: quotient = (rem_in << FRACTION_BITS) / lim.
// One quotient bit per stage; depends on ipc_pkg.
module ipc_divider #(
    parameter int FRACTION_BITS = ipc_pkg::DEF_FRACTION_BITS
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic [ipc_pkg::REM_W-1:0]   in_rem,
    input  ipc_pkg::ipc_side_t          in_side,
    input  logic [ipc_pkg::LIM_W-1:0]   lim,
    output logic                        out_valid,
    output logic [FRACTION_BITS-1:0]    out_quot,
    output ipc_pkg::ipc_side_t          out_side
);
    import ipc_pkg::*;

    logic                     valid_reg [FRACTION_BITS];
    logic [REM_W-1:0]         rem_reg   [FRACTION_BITS];
    logic [FRACTION_BITS-1:0] quot_reg  [FRACTION_BITS];
    ipc_side_t                side_reg  [FRACTION_BITS];

    logic                     valid_src [FRACTION_BITS+1];
    logic [REM_W-1:0]         rem_src   [FRACTION_BITS+1];
    logic [FRACTION_BITS-1:0] quot_src  [FRACTION_BITS+1];
    ipc_side_t                side_src  [FRACTION_BITS+1];

    assign valid_src[0] = in_valid;
    assign rem_src[0]   = in_rem;
    assign quot_src[0]  = '0;
    assign side_src[0]  = in_side;

    for (genvar j = 0; j < FRACTION_BITS; j++)
    begin : g_step
        logic [REM_W:0]   dbl;
        logic             ge;
        logic [REM_W-1:0] rem_next;

        // Shift the remainder, subtract the divisor when it fits
        assign dbl      = {rem_src[j], 1'b0};
        assign ge       = (dbl >= lim);
        assign rem_next = ge ? REM_W'(dbl - lim) : dbl[REM_W-1:0];

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[j] <= 1'b0;
            end
            else
            begin
                valid_reg[j] <= valid_src[j];
            end
        end

        always_ff @(posedge clk)
        begin
            rem_reg[j]  <= rem_next;
            quot_reg[j] <= {quot_src[j][FRACTION_BITS-2:0], ge};
            side_reg[j] <= side_src[j];
        end

        assign valid_src[j+1] = valid_reg[j];
        assign rem_src[j+1]   = rem_reg[j];
        assign quot_src[j+1]  = quot_reg[j];
        assign side_src[j+1]  = side_reg[j];
    end

    assign out_valid = valid_src[FRACTION_BITS];
    assign out_quot  = quot_src[FRACTION_BITS];
    assign out_side  = side_src[FRACTION_BITS];

endmodule

@@ design/ipc_cos_rom.sv @@
// Quarter-wave cosine ROM in Q16 with registered read.
// Contents built at elaboration by a fixed-point Taylor series; uses ipc_pkg.
module ipc_cos_rom #(
    parameter int COSINE_TABLE_DEPTH = ipc_pkg::DEF_COSINE_TABLE_DEPTH
) (
    input  logic                                  clk,
    input  logic [$clog2(COSINE_TABLE_DEPTH+1)-1:0] addr,
    output logic [16:0]                           data
);
    import ipc_pkg::*;

    localparam int AW = $clog2(COSINE_TABLE_DEPTH + 1);
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
    localparam longint unsigned DENOM [1:8] = '{64'd2, 64'd12, 64'd30, 64'd56,
                                                64'd90, 64'd132, 64'd182, 64'd240};

    typedef logic [16:0] rom_t [0:COSINE_TABLE_DEPTH];

    function automatic rom_t build_rom();
        rom_t             rom;
        longint unsigned  x;
        longint unsigned  x2;
        longint unsigned  term;
        longint unsigned  v;
        longint           sum;
        for (int i = 0; i <= COSINE_TABLE_DEPTH; i++)
        begin
            x    = longint'(i) * HALF_PI_Q30 / COSINE_TABLE_DEPTH;
            x2   = (x * x) >> 30;
            term = 64'd1 << 30;
            sum  = longint'(term);
            for (int k = 1; k <= 8; k++)
            begin
                term = ((term * x2) >> 30) / DENOM[k];
                if (k % 2 == 1)
                    sum = sum - longint'(term);
                else
                    sum = sum + longint'(term);
            end
            if (sum < 0)
                sum = 0;
            v = (longint'(sum) + 64'd8192) >> 14;
            if (v > 64'd65536)
                v = 64'd65536;
            rom[i] = v[16:0];
        end
        return rom;
    endfunction

    localparam rom_t COS_ROM = build_rom();

    logic [AW-1:0] addr_q;
    assign addr_q = addr;

    // Register the table read
    always_ff @(posedge clk)
    begin
        data <= COS_ROM[addr_q];
    end

endmodule

@@ design/ipc_color.sv @@
// Color stages after the divider: Bernstein products, cosine phase and
// lookup, greyscale ramp, final select. Uses ipc_pkg and ipc_cos_rom.
module ipc_color #(
    parameter int FRACTION_BITS      = ipc_pkg::DEF_FRACTION_BITS,
    parameter int COSINE_TABLE_DEPTH = ipc_pkg::DEF_COSINE_TABLE_DEPTH
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    input  logic [FRACTION_BITS-1:0] t,
    input  ipc_pkg::ipc_side_t       side,
    input  ipc_pkg::ipc_mode_e       mode,
    output logic                     done,
    output logic [7:0]               red,
    output logic [7:0]               green,
    output logic [7:0]               blue,
    output logic                     index_out_of_range
);
    import ipc_pkg::*;

    localparam int F      = FRACTION_BITS;
    localparam int QW     = F + 1;
    localparam int DEPTH  = COSINE_TABLE_DEPTH;
    localparam int TURN   = 4 * DEPTH;
    localparam int TRIPLE = 3 * TURN;
    localparam int TRI_W  = $clog2(TRIPLE + 1);
    localparam int PH_W   = $clog2(16 * DEPTH);
    localparam int AW     = $clog2(DEPTH + 1);
    localparam int OFF1   = (TURN + 5) / 10;
    localparam int OFF2   = (2 * TURN + 5) / 10;
    localparam logic [QW-1:0] ONE_Q = {1'b1, {F{1'b0}}};

    function automatic logic [QW-1:0] mulq(input logic [QW-1:0] a, input logic [QW-1:0] b);
        logic [2*QW-1:0] p;
        p = a * b;
        return p[F+QW-1:F];
    endfunction

    function automatic logic [7:0] sat8(input logic [15:0] x);
        return (x > 16'd255) ? 8'hff : x[7:0];
    endfunction

    // ---------------- stage 1: squares, cosine base, grey product
    logic            v1_reg;
    ipc_side_t       side1_reg;
    logic [QW-1:0]   t1_reg, s1_reg, t2_1_reg, s2_1_reg;
    logic [PH_W-1:0] base1_reg;
    logic [F+7:0]    grey1_reg;

    logic [QW-1:0]      t_q, s_q;
    logic [F+TRI_W-1:0] base_prod;
    logic [F+7:0]       grey_prod;

    assign t_q       = {1'b0, t};
    assign s_q       = ONE_Q - t_q;
    assign base_prod = (F+TRI_W)'(t) * (F+TRI_W)'(TRIPLE);
    assign grey_prod = (F+8)'(t) * (F+8)'(255);

    always_ff @(posedge clk)
    begin
        side1_reg <= side;
        t1_reg    <= t_q;
        s1_reg    <= s_q;
        t2_1_reg  <= mulq(t_q, t_q);
        s2_1_reg  <= mulq(s_q, s_q);
        base1_reg <= PH_W'(base_prod[F+TRI_W-1:F]);
        grey1_reg <= grey_prod;
    end

    // ---------------- stage 2: cubes, green product, phase quarter-turn count
    logic            v2_reg;
    ipc_side_t       side2_reg;
    logic [QW-1:0]   t_2_reg, s_2_reg, t3_2_reg, s3_2_reg, qg2_reg;
    logic [F+7:0]    grey2_reg;
    logic [PH_W-1:0] ph2_reg [3];
    logic [3:0]      k2_reg  [3];

    logic [PH_W-1:0] ph_c [3];
    logic [3:0]      k_c  [3];

    always_comb
    begin
        ph_c[0] = base1_reg;
        ph_c[1] = base1_reg + PH_W'(OFF1);
        ph_c[2] = base1_reg + PH_W'(OFF2);
    end

    for (genvar i = 0; i < 3; i++)
    begin : g_quad
        logic [11:0] therm;
        // Count how many quarter-turn boundaries the phase has passed
        always_comb
        begin
            for (int j = 1; j <= 12; j++)
            begin
                therm[j-1] = (ph_c[i] >= PH_W'(j * DEPTH));
            end
        end
        assign k_c[i] = 4'($countones(therm));
    end

    always_ff @(posedge clk)
    begin
        side2_reg <= side1_reg;
        t_2_reg   <= t1_reg;
        s_2_reg   <= s1_reg;
        t3_2_reg  <= mulq(t1_reg, t2_1_reg);
        s3_2_reg  <= mulq(s1_reg, s2_1_reg);
        qg2_reg   <= mulq(s2_1_reg, t2_1_reg);
        grey2_reg <= grey1_reg;
        for (int i = 0; i < 3; i++)
        begin
            ph2_reg[i] <= ph_c[i];
            k2_reg[i]  <= k_c[i];
        end
    end

    // ---------------- stage 3: red/blue products, table address
    logic          v3_reg;
    ipc_side_t     side3_reg;
    logic [QW-1:0] qr3_reg, qb3_reg, qg3_reg;
    logic [F+7:0]  grey3_reg;
    logic [AW-1:0] addr3_reg [3];
    logic [1:0]    quad3_reg [3];

    logic [AW-1:0] addr_c [3];

    for (genvar i = 0; i < 3; i++)
    begin : g_addr
        logic [PH_W-1:0] rem_ph;
        logic [AW-1:0]   r;
        // Fold the phase into one quarter and mirror odd quarters
        assign rem_ph    = ph2_reg[i] - PH_W'(int'(k2_reg[i]) * DEPTH);
        assign r         = rem_ph[AW-1:0];
        assign addr_c[i] = k2_reg[i][0] ? (AW'(DEPTH) - r) : r;
    end

    always_ff @(posedge clk)
    begin
        side3_reg <= side2_reg;
        qr3_reg   <= mulq(s_2_reg, t3_2_reg);
        qb3_reg   <= mulq(s3_2_reg, t_2_reg);
        qg3_reg   <= qg2_reg;
        grey3_reg <= grey2_reg;
        for (int i = 0; i < 3; i++)
        begin
            addr3_reg[i] <= addr_c[i];
            quad3_reg[i] <= k2_reg[i][1:0];
        end
    end

    // ---------------- stage 4: scale products, cosine table read
    logic          v4_reg;
    ipc_side_t     side4_reg;
    logic [QW+11:0] pr4_reg, pg4_reg;
    logic [QW+12:0] pb4_reg;
    logic [F+7:0]   grey4_reg;
    logic [1:0]     quad4_reg [3];
    logic [16:0]    mag4      [3];

    for (genvar i = 0; i < 3; i++)
    begin : g_rom
        ipc_cos_rom #(
            .COSINE_TABLE_DEPTH (COSINE_TABLE_DEPTH)
        ) u_rom (
            .clk  (clk),
            .addr (addr3_reg[i]),
            .data (mag4[i])
        );
    end

    always_ff @(posedge clk)
    begin
        side4_reg <= side3_reg;
        pr4_reg   <= (QW+12)'(qr3_reg) * (QW+12)'(2295);
        pg4_reg   <= (QW+12)'(qg3_reg) * (QW+12)'(3825);
        pb4_reg   <= (QW+13)'(qb3_reg) * (QW+13)'(4335);
        grey4_reg <= grey3_reg;
        for (int i = 0; i < 3; i++)
        begin
            quad4_reg[i] <= quad3_reg[i];
        end
    end

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    // ---------------- output stage: bias cosine, saturate, select
    logic [7:0] cos_ch [3];

    for (genvar i = 0; i < 3; i++)
    begin : g_bias
        logic [17:0] biased;
        logic [25:0] scaled;
        assign biased    = (quad4_reg[i][1] ^ quad4_reg[i][0])
                           ? (18'd65536 - 18'(mag4[i])) : (18'd65536 + 18'(mag4[i]));
        assign scaled    = 26'(biased) * 26'd255;
        assign cos_ch[i] = sat8(16'(scaled[25:17]));
    end

    logic [7:0] bern_r, bern_g, bern_b, grey_v;
    logic [7:0] red_next, green_next, blue_next;
    logic       flag_next;

    assign bern_r = sat8(16'(pr4_reg[QW+11:F]));
    assign bern_g = sat8(16'(pg4_reg[QW+11:F]));
    assign bern_b = sat8(16'(pb4_reg[QW+12:F+1]));
    assign grey_v = sat8(16'(grey4_reg[F+7:F]));

    always_comb
    begin
        red_next   = 8'h00;
        green_next = 8'h00;
        blue_next  = 8'h00;
        flag_next  = side4_reg.oob;
        if (!side4_reg.oob)
        begin
            unique case (mode)
                MODE_BERNSTEIN:
                begin
                    if (!side4_reg.last)
                    begin
                        red_next   = bern_r;
                        green_next = bern_g;
                        blue_next  = bern_b;
                    end
                end
                MODE_COSINE:
                begin
                    red_next   = cos_ch[0];
                    green_next = cos_ch[1];
                    blue_next  = cos_ch[2];
                end
                MODE_KALEIDO:
                begin
                    if (!side4_reg.last)
                    begin
                        red_next   = side4_reg.kcolor[23:16];
                        green_next = side4_reg.kcolor[15:8];
                        blue_next  = side4_reg.kcolor[7:0];
                    end
                end
                MODE_GREY:
                begin
                    red_next   = grey_v;
                    green_next = grey_v;
                    blue_next  = grey_v;
                end
                MODE_MONO:
                begin
                    if (!side4_reg.last)
                    begin
                        red_next   = 8'hff;
                        green_next = 8'hff;
                        blue_next  = 8'hff;
                    end
                end
                default:
                begin
                    red_next = 8'h00;
                end
            endcase
        end
    end

    logic       done_reg;
    logic [7:0] red_reg, green_reg, blue_reg;
    logic       flag_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        red_reg   <= red_next;
        green_reg <= green_next;
        blue_reg  <= blue_next;
        flag_reg  <= flag_next;
    end

    assign done               = done_reg;
    assign red                = red_reg;
    assign green              = green_reg;
    assign blue               = blue_reg;
    assign index_out_of_range = flag_reg;

endmodule

@@ design/iteration_palette_color_top.sv @@
// Top level of the iteration palette color block: config registers, entry
// stage, divider and color stages. Uses ipc_pkg, ipc_divider, ipc_color.
//
//  port group     direction  handshake
//  apb config     in/out     psel, penable, pwrite, pready (always high)
//  request        in         start while busy low, color_index
//  result         out        done strobe, red, green, blue, index_out_of_range
//
// One request per clock; busy is never raised.
// Each request passes the entry stage, the divider that forms one
// quotient bit per stage, four color stages and the output register.
// Reset clears the configuration to Bernstein mode, limit 64, and empties
// the pipeline. Results cannot be stalled: done is high for a single cycle per result.
module iteration_palette_color_top #(
    parameter int FRACTION_BITS      = ipc_pkg::DEF_FRACTION_BITS,
    parameter int COSINE_TABLE_DEPTH = ipc_pkg::DEF_COSINE_TABLE_DEPTH
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [2:0]                paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic                      pready,
    input  logic                      start,
    output logic                      busy,
    input  logic [ipc_pkg::IDX_W-1:0] color_index,
    output logic                      done,
    output logic [7:0]                red,
    output logic [7:0]                green,
    output logic [7:0]                blue,
    output logic                      index_out_of_range
);
    import ipc_pkg::*;

    `include "iteration_palette_color_top_macros.svh"

    localparam int LATENCY = FRACTION_BITS + 6;
    localparam logic [LIM_W-1:0] LIM_MAX = LIM_W'(MAX_ITERATIONS);

    // Configuration registers
    ipc_mode_e        mode_reg;
    logic [LIM_W-1:0] limit_reg;
    logic             cfg_wr;

    assign cfg_wr = psel & penable & pwrite;
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_LIMIT) ? 32'(limit_reg) : 32'(mode_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_RESET;
            limit_reg <= LIMIT_RESET;
        end
        else if (cfg_wr)
        begin
            if (paddr[2] == REG_LIMIT)
                limit_reg <= pwdata[LIM_W-1:0];
            else
                mode_reg <= ipc_mode_e'(pwdata[2:0]);
        end
    end

    // Entry stage: capture the request
    logic             in_valid_reg;
    logic [IDX_W-1:0] idx_reg;

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= start & ~busy;
    end

    always_ff @(posedge clk)
    begin
        if (start)
            idx_reg <= color_index;
    end

    // Saturate the limit and flag range, last entry, kaleidoscope color
    logic [LIM_W-1:0] lim_eff;
    ipc_side_t        side_in;

    assign lim_eff        = (limit_reg > LIM_MAX) ? LIM_MAX : limit_reg;
    assign side_in.oob    = ({1'b0, idx_reg} >= lim_eff);
    assign side_in.last   = ({1'b0, idx_reg} == (lim_eff - LIM_W'(1)));
    assign side_in.kcolor = KALEIDO_BASE + (24'(idx_reg) * KALEIDO_STEP);

    logic                     div_valid;
    logic [FRACTION_BITS-1:0] div_quot;
    ipc_side_t                div_side;

    ipc_divider #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_divider (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid_reg),
        .in_rem    (idx_reg),
        .in_side   (side_in),
        .lim       (lim_eff),
        .out_valid (div_valid),
        .out_quot  (div_quot),
        .out_side  (div_side)
    );

    ipc_color #(
        .FRACTION_BITS      (FRACTION_BITS),
        .COSINE_TABLE_DEPTH (COSINE_TABLE_DEPTH)
    ) u_color (
        .clk                (clk),
        .rst_n              (rst_n),
        .in_valid           (div_valid),
        .t                  (div_quot),
        .side               (div_side),
        .mode               (mode_reg),
        .done               (done),
        .red                (red),
        .green              (green),
        .blue               (blue),
        .index_out_of_range (index_out_of_range)
    );

    `IPC_ASSERT_IMPLY(a_done_has_request, done, $past(start && !busy, LATENCY))
    `IPC_ASSERT_NEXT(a_request_gives_done, start && !busy, ##(LATENCY-1) done)
    `IPC_ASSERT_IMPLY(a_oob_black, done && index_out_of_range,
                      red == 8'h00 && green == 8'h00 && blue == 8'h00)

endmodule

@@ test/iteration_palette_color_checker.sv @@
// Watches the request, result and APB ports of iteration_palette_color_top.
// It predicts every color, compares each result and reports the error count.
// Depends on ipc_pkg.
`timescale 1ns / 1ps

module iteration_palette_color_checker (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic                       pready,
    input  logic [2:0]                 paddr,
    input  logic [31:0]                pwdata,
    input  logic                       start,
    input  logic                       busy,
    input  logic [ipc_pkg::IDX_W-1:0]  color_index,
    input  logic                       done,
    input  logic [7:0]                 red,
    input  logic [7:0]                 green,
    input  logic [7:0]                 blue,
    input  logic                       index_out_of_range,
    output int                         errors,
    output int                         pending
);
    import ipc_pkg::*;

    localparam int FRAC      = DEF_FRACTION_BITS;
    localparam int DEPTH     = DEF_COSINE_TABLE_DEPTH;
    localparam int TURN      = 4 * DEPTH;
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        logic       oob;
    } color_t;

    longint unsigned cos_rom [0:DEPTH];
    logic [2:0]         mode_q;
    logic [LIM_W-1:0]   limit_q;
    color_t             color_q [$];

    assign pending = color_q.size();

    // Fill the quarter-wave cosine table with a Taylor series in Q30
    initial
    begin
        longint unsigned x, x2, term, v;
        longint          sum;
        for (int i = 0; i <= DEPTH; i++)
        begin
            x    = longint'(i) * HALF_PI_Q30 / DEPTH;
            x2   = (x * x) >> 30;
            term = 64'd1 << 30;
            sum  = longint'(term);
            for (int k = 1; k <= 8; k++)
            begin
                term = ((term * x2) >> 30) / longint'((2 * k - 1) * (2 * k));
                if (k % 2 == 1)
                    sum = sum - longint'(term);
                else
                    sum = sum + longint'(term);
            end
            if (sum < 0)
                sum = 0;
            v = (longint'(sum) + 8192) >> 14;
            if (v > 65536)
                v = 65536;
            cos_rom[i] = v;
        end
    end

    function automatic longint unsigned fmul(longint unsigned a, longint unsigned b);
        return (a * b) >> FRAC;
    endfunction

    function automatic logic [7:0] clip8(longint unsigned v);
        return (v > 255) ? 8'd255 : v[7:0];
    endfunction

    function automatic logic [7:0] cos_level(longint unsigned phase);
        int unsigned p, quad, r;
        longint unsigned mag, biased;
        p    = phase % TURN;
        quad = p / DEPTH;
        r    = p % DEPTH;
        mag  = (quad == 0 || quad == 2) ? cos_rom[r] : cos_rom[DEPTH - r];
        biased = (quad == 1 || quad == 2) ? 65536 - mag : 65536 + mag;
        return clip8((biased * 255) >> 17);
    endfunction

    // Work out the palette color of one index under the current registers
    function automatic color_t palette_color(logic [IDX_W-1:0] idx);
        color_t c;
        longint unsigned lim, t, s, t2, s2, base;
        logic [23:0] k;
        logic is_last;
        c   = '0;
        lim = (limit_q > MAX_ITERATIONS) ? MAX_ITERATIONS : limit_q;
        if (idx >= lim)
        begin
            c.oob = 1'b1;
            return c;
        end
        t       = (longint'(idx) << FRAC) / lim;
        s       = (64'd1 << FRAC) - t;
        is_last = (idx == lim - 1);
        case (mode_q)
            MODE_BERNSTEIN:
                if (!is_last)
                begin
                    t2  = fmul(t, t);
                    s2  = fmul(s, s);
                    c.r = clip8((fmul(s, fmul(t, t2)) * 2295) >> FRAC);
                    c.g = clip8((fmul(s2, t2) * 3825) >> FRAC);
                    c.b = clip8((fmul(fmul(s, s2), t) * 4335) >> (FRAC + 1));
                end
            MODE_COSINE:
            begin
                base = (3 * t * TURN) >> FRAC;
                c.r  = cos_level(base);
                c.g  = cos_level(base + (TURN + 5) / 10);
                c.b  = cos_level(base + (2 * TURN + 5) / 10);
            end
            MODE_KALEIDO:
                if (!is_last)
                begin
                    k   = KALEIDO_BASE + 24'(idx) * KALEIDO_STEP;
                    c.r = k[23:16];
                    c.g = k[15:8];
                    c.b = k[7:0];
                end
            MODE_GREY:
            begin
                c.r = clip8((t * 255) >> FRAC);
                c.g = c.r;
                c.b = c.r;
            end
            MODE_MONO:
                if (!is_last)
                    c = {8'd255, 8'd255, 8'd255, 1'b0};
            default: ;
        endcase
        return c;
    endfunction

    // Track register writes, queue predictions, compare results
    always @(posedge clk or negedge rst_n)
    begin
        color_t want;
        if (!rst_n)
        begin
            mode_q  <= MODE_RESET;
            limit_q <= LIMIT_RESET;
            errors  <= 0;
            color_q.delete();
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                if (paddr[2] == REG_LIMIT)
                    limit_q <= pwdata[LIM_W-1:0];
                else
                    mode_q <= pwdata[2:0];
            end
            if (start && !busy)
                color_q.push_back(palette_color(color_index));
            if (done)
            begin
                if (color_q.size() == 0)
                begin
                    $error("result with no request pending");
                    errors <= errors + 1;
                end
                else
                begin
                    want = color_q.pop_front();
                    if (want.r !== red)
                        $error("red: expected %0d, got %0d", want.r, red);
                    if (want.g !== green)
                        $error("green: expected %0d, got %0d", want.g, green);
                    if (want.b !== blue)
                        $error("blue: expected %0d, got %0d", want.b, blue);
                    if (want.oob !== index_out_of_range)
                        $error("index_out_of_range: expected %0d, got %0d",
                               want.oob, index_out_of_range);
                    if (want !== {red, green, blue, index_out_of_range})
                        errors <= errors + 1;
                end
            end
        end
    end

endmodule

@@ test/iteration_palette_color_top_tb.sv @@
// Stimulus and verdict for iteration_palette_color_top: walks palette modes
// and limits over APB, sends color requests. Uses ipc_pkg and the checker.
`timescale 1ns / 1ps

module iteration_palette_color_top_tb;
    import ipc_pkg::*;

    localparam int PHASES = 26;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [2:0]        paddr = '0;
    logic [31:0]       pwdata = '0;
    logic [31:0]       prdata;
    logic              pready;
    logic              start = 1'b0;
    logic              busy;
    logic [IDX_W-1:0]  color_index = '0;
    logic              done;
    logic [7:0]        red, green, blue;
    logic              index_out_of_range;
    int                errors;
    int                pending;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    iteration_palette_color_top dut (
        .clk(clk), .rst_n(rst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
        .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .start(start), .busy(busy), .color_index(color_index), .done(done),
        .red(red), .green(green), .blue(blue),
        .index_out_of_range(index_out_of_range)
    );

    iteration_palette_color_checker checker_i (
        .clk(clk), .rst_n(rst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
        .pready(pready), .paddr(paddr), .pwdata(pwdata), .start(start),
        .busy(busy), .color_index(color_index), .done(done), .red(red),
        .green(green), .blue(blue), .index_out_of_range(index_out_of_range),
        .errors(errors), .pending(pending)
    );

    // Write one register: setup cycle, then access cycle
    task automatic reg_write(logic sel, logic [31:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {sel, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Hold until every predicted color has come out, then let the pipe drain
    task automatic drain();
        while (pending != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);
    endtask

    // Send one request, then sometimes idle for a random gap
    task automatic send_index(logic [IDX_W-1:0] idx);
        int gap;
        start       <= 1'b1;
        color_index <= idx;
        do
            @(posedge clk);
        while (busy);
        @(negedge clk);
        case ($urandom_range(0, 19))
            0, 1, 2, 3:   gap = $urandom_range(1, 3);
            4:            gap = $urandom_range(15, 60);
            default:      gap = 0;
        endcase
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    initial
    begin
        logic [2:0]       mode;
        logic [LIM_W-1:0] limit;
        int               eff, count;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: reset settings, index extremes
        send_index('0);
        send_index(12'd63);
        send_index(12'd64);
        send_index('1);
        start <= 1'b0;
        drain();

        for (int ph = 0; ph < PHASES; ph++)
        begin
            mode = 3'(ph % 8);
            case (ph % 13)
                0:  limit = 13'd1;
                1:  limit = 13'd4096;
                2:  limit = 13'd0;
                3:  limit = 13'd8191;
                4:  limit = 13'd2;
                5:  limit = 13'd4095;
                6:  limit = 13'd4097;
                7:  limit = 13'd64;
                8:  limit = 13'd3;
                default: limit = 13'($urandom_range(1, 4096));
            endcase
            reg_write(REG_MODE, {29'(0), mode} | ($urandom() & 32'hffff_fff8));
            reg_write(REG_LIMIT, {19'(0), limit} | ($urandom() & 32'hffff_e000));
            eff = (limit > MAX_ITERATIONS) ? MAX_ITERATIONS : limit;

            // Edges of the range: first, last entry, first out of range, top
            send_index('0);
            if (eff > 0)
                send_index(IDX_W'(eff - 1));
            if (eff < 4096)
                send_index(IDX_W'(eff));
            send_index('1);

            count = 55;
            for (int i = 0; i < count; i++)
            begin
                if (i == count / 2)
                begin
                    start <= 1'b0;
                    while (pending != 0)
                        @(posedge clk);
                    @(negedge clk);
                end
                if (eff > 0 && $urandom_range(0, 9) != 0)
                    send_index(IDX_W'($urandom_range(0, eff - 1)));
                else
                    send_index(IDX_W'($urandom()));
            end
            start <= 1'b0;
            drain();
        end

        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        #4ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

@@ iteration_palette_color_top.f @@
+incdir+design
design/ipc_pkg.sv
design/ipc_divider.sv
design/ipc_cos_rom.sv
design/ipc_color.sv
design/iteration_palette_color_top.sv
test/iteration_palette_color_checker.sv
test/iteration_palette_color_top_tb.sv
